>>> sv/assert_macros.svh
// Assertion macros for the biconnected component finder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BCF_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BCF_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bcf_pkg.sv
// Shared types, constants and codes for the biconnected component finder
`default_nettype none

package bcf_pkg;

  // Field and store sizes fixed by the 6-bit vertex fields
  localparam int VERT_W          = 6;
  localparam int MAX_VERTICES    = 64;
  localparam int MAX_ENTRIES_DEF = 128;
  localparam int STACK_DEPTH     = 64;
  localparam int RESULT_CAP      = 64;
  localparam int CNT_W           = 7;   // counts 0..64
  localparam int TIME_W          = 7;
  localparam int COMP_W          = 6;
  localparam int VC_W            = 7;

  // Command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_RUN    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Edge stack entry
  typedef struct packed {
    logic [VERT_W-1:0] from_v;
    logic [VERT_W-1:0] to_v;
  } edge_t;

  // Buffered result entry
  typedef struct packed {
    edge_t             edge_v;
    logic [COMP_W-1:0] comp;
    logic              last;
  } res_t;

  // Controller states
  typedef enum logic [4:0] {
    S_IDLE, S_APP1, S_APP2, S_INIT, S_ROOT, S_RENT, S_STEP, S_EDGE, S_DEC,
    S_RET, S_RET2, S_POP, S_POPW, S_DRAIN, S_DRAINW, S_ORD, S_OLD, S_OWAIT
  } state_t;

  // Datapath micro-operations
  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLEAR, OP_APP1, OP_APP2, OP_INIT, OP_ROOT_RD,
    OP_RENT, OP_STEP_RD, OP_EDGE, OP_DEC, OP_RET, OP_RET2, OP_POP_RD,
    OP_POP_EMIT, OP_DRAIN_EMIT, OP_ROOT_NEXT, OP_ORD, OP_OLD, OP_OACK
  } op_t;

  // Datapath status toward the controller
  typedef struct packed {
    logic app_bad;
    logic cur_null;
    logic depth_one;
    logic ret_pop;
    logic pop_last;
    logic stack_empty;
    logic root_done;
    logic root_vis;
    logic res_empty;
    logic out_last;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/bcf_ram.sv
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module bcf_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/bcf_datapath.sv
// Datapath: graph stores, search frames, edge stack, result buffer
`default_nettype none

module bcf_datapath #(
  parameter int MAX_ENTRIES = bcf_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bcf_pkg::op_t                    op,
  output bcf_pkg::sts_t                        sts,
  input  wire logic [bcf_pkg::VERT_W-1:0]      in_source_vertex,
  input  wire logic [bcf_pkg::VERT_W-1:0]      in_neighbor_vertex,
  input  wire logic                            cfg_write_en,
  input  wire logic [bcf_pkg::VC_W-1:0]        cfg_write_data,
  output logic      [bcf_pkg::VERT_W-1:0]      out_edge_from,
  output logic      [bcf_pkg::VERT_W-1:0]      out_edge_to,
  output logic      [bcf_pkg::COMP_W-1:0]      out_component_index,
  output logic                                 out_last_in_component,
  output logic                                 out_last_of_run,
  output logic                                 out_overflow
);

  localparam int EW   = $clog2(MAX_ENTRIES);
  localparam int LW   = $clog2(MAX_ENTRIES + 1);
  localparam int VW   = bcf_pkg::VERT_W;
  localparam int CW   = bcf_pkg::CNT_W;
  localparam int TW   = bcf_pkg::TIME_W;
  localparam int SAW  = $clog2(bcf_pkg::STACK_DEPTH);
  localparam int RAW  = $clog2(bcf_pkg::RESULT_CAP);
  localparam int NV   = bcf_pkg::MAX_VERTICES;
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ENTRIES);

  typedef struct packed {
    logic [VW-1:0] vert;
    logic [VW-1:0] par;
    logic          hasp;
    logic [LW-1:0] cur;
    logic [CW-1:0] mark;
    logic [TW-1:0] disc;
    logic [TW-1:0] low;
  } frame_t;

  // Control and payload registers
  logic [bcf_pkg::VC_W-1:0]   vc_r;
  logic [VW-1:0]              s_r, nb_r;
  logic [LW-1:0]              ecount_r;
  logic [NV-1:0]              hv_r, vis_r;
  logic                       ovf_r;
  logic [VW-1:0]              u_r, par_r, v_r;
  logic                       hasp_r;
  logic [LW-1:0]              cur_r;
  logic [CW-1:0]              mark_r, pmark_r, depth_r, root_r, ssize_r, resn_r, k_r;
  logic [TW-1:0]              disc_u_r, low_u_r, time_r;
  logic [bcf_pkg::COMP_W-1:0] comp_r;

  // Memory read data
  logic [VW-1:0]      tgt_rd;
  logic [LW-1:0]      link_rd;
  logic [EW-1:0]      head_rd, tail_rd;
  logic [TW-1:0]      disc_rd;
  logic [$bits(frame_t)-1:0] frame_rdv;
  frame_t             frame_rd;
  bcf_pkg::edge_t     es_rd;
  bcf_pkg::res_t      res_rd;

  // Memory write controls
  logic          link_we, head_we, disc_we, frame_we, es_we, res_we;
  logic [EW-1:0] link_waddr;
  logic [LW-1:0] link_wdata;
  logic [VW-1:0] head_raddr, disc_waddr;
  bcf_pkg::res_t res_wd;

  // Derived values
  logic [bcf_pkg::VC_W-1:0] n_act;
  logic [CW-1:0] depth_m1, depth_m2, ssize_m1;
  logic [TW-1:0] time_inc;
  logic          skip, tree, back, push, emit, emit_last, stack_room, res_room;
  frame_t        top_frame;

  assign n_act    = (vc_r > bcf_pkg::VC_W'(NV)) ? bcf_pkg::VC_W'(NV) : vc_r;
  assign depth_m1 = depth_r - CW'(1);
  assign depth_m2 = depth_r - CW'(2);
  assign ssize_m1 = ssize_r - CW'(1);
  assign time_inc = time_r + TW'(1);
  assign frame_rd = frame_t'(frame_rdv);
  assign top_frame = '{vert: u_r, par: par_r, hasp: hasp_r, cur: cur_r, mark: mark_r,
                       disc: disc_u_r, low: low_u_r};

  // Edge classification at the decide step
  always_comb begin
    skip       = ({1'b0, v_r} >= n_act) || (hasp_r && (v_r == par_r));
    tree       = !skip && !vis_r[v_r];
    back       = !skip && vis_r[v_r] && (disc_rd < disc_u_r);
    push       = (op == bcf_pkg::OP_DEC) && (tree || back);
    stack_room = ssize_r < CW'(bcf_pkg::STACK_DEPTH);
    res_room   = resn_r < CW'(bcf_pkg::RESULT_CAP);
    emit       = (op == bcf_pkg::OP_POP_EMIT) || (op == bcf_pkg::OP_DRAIN_EMIT);
    emit_last  = (op == bcf_pkg::OP_DRAIN_EMIT) || (ssize_r == pmark_r);
  end

  // Status toward the controller
  always_comb begin
    sts.app_bad     = (ecount_r >= NULL_LINK) || ({1'b0, s_r} >= n_act) ||
                      ({1'b0, nb_r} >= n_act);
    sts.cur_null    = cur_r == NULL_LINK;
    sts.depth_one   = depth_r == CW'(1);
    sts.ret_pop     = (low_u_r >= frame_rd.disc) && (ssize_r > mark_r);
    sts.pop_last    = ssize_r == pmark_r;
    sts.stack_empty = ssize_r == '0;
    sts.root_done   = root_r >= n_act;
    sts.root_vis    = vis_r[root_r[VW-1:0]];
    sts.res_empty   = resn_r == '0;
    sts.out_last    = out_last_of_run;
  end

  // Memory port steering
  always_comb begin
    link_we    = ((op == bcf_pkg::OP_APP1) && !sts.app_bad) ||
                 ((op == bcf_pkg::OP_APP2) && hv_r[s_r]);
    link_waddr = (op == bcf_pkg::OP_APP1) ? ecount_r[EW-1:0] : tail_rd;
    link_wdata = (op == bcf_pkg::OP_APP1) ? NULL_LINK : ecount_r;
    head_we    = (op == bcf_pkg::OP_APP2) && !hv_r[s_r];
    head_raddr = (op == bcf_pkg::OP_ROOT_RD) ? root_r[VW-1:0] : tgt_rd;
    disc_we    = (op == bcf_pkg::OP_RENT) || ((op == bcf_pkg::OP_DEC) && tree);
    disc_waddr = (op == bcf_pkg::OP_RENT) ? root_r[VW-1:0] : v_r;
    frame_we   = (op == bcf_pkg::OP_DEC) && tree;
    es_we      = push && stack_room;
    res_we     = emit && res_room;
    res_wd     = '{edge_v: es_rd, comp: comp_r, last: emit_last};
  end

  bcf_ram #(.W(VW), .D(MAX_ENTRIES)) u_tgt (
    .clk(clk), .we((op == bcf_pkg::OP_APP1) && !sts.app_bad),
    .waddr(ecount_r[EW-1:0]), .wdata(nb_r), .raddr(cur_r[EW-1:0]), .rdata(tgt_rd));

  bcf_ram #(.W(LW), .D(MAX_ENTRIES)) u_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(cur_r[EW-1:0]), .rdata(link_rd));

  bcf_ram #(.W(EW), .D(NV)) u_head (
    .clk(clk), .we(head_we), .waddr(s_r), .wdata(ecount_r[EW-1:0]),
    .raddr(head_raddr), .rdata(head_rd));

  bcf_ram #(.W(EW), .D(NV)) u_tail (
    .clk(clk), .we(op == bcf_pkg::OP_APP2), .waddr(s_r), .wdata(ecount_r[EW-1:0]),
    .raddr(s_r), .rdata(tail_rd));

  bcf_ram #(.W(TW), .D(NV)) u_disc (
    .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(time_inc),
    .raddr(tgt_rd), .rdata(disc_rd));

  bcf_ram #(.W($bits(frame_t)), .D(NV)) u_frame (
    .clk(clk), .we(frame_we), .waddr(depth_m1[VW-1:0]), .wdata(top_frame),
    .raddr(depth_m2[VW-1:0]), .rdata(frame_rdv));

  bcf_ram #(.W($bits(bcf_pkg::edge_t)), .D(bcf_pkg::STACK_DEPTH)) u_estack (
    .clk(clk), .we(es_we), .waddr(ssize_r[SAW-1:0]), .wdata({u_r, v_r}),
    .raddr(ssize_m1[SAW-1:0]), .rdata(es_rd));

  bcf_ram #(.W($bits(bcf_pkg::res_t)), .D(bcf_pkg::RESULT_CAP)) u_res (
    .clk(clk), .we(res_we), .waddr(resn_r[RAW-1:0]), .wdata(res_wd),
    .raddr(k_r[RAW-1:0]), .rdata(res_rd));

  // Register updates per micro-operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r     <= bcf_pkg::VC_W'(1);
      ecount_r <= '0;
      hv_r     <= '0;
      vis_r    <= '0;
      ovf_r    <= 1'b0;
      depth_r  <= '0;
      root_r   <= '0;
      ssize_r  <= '0;
      resn_r   <= '0;
      k_r      <= '0;
      time_r   <= '0;
      comp_r   <= '0;
    end else begin
      if (cfg_write_en) begin
        vc_r <= cfg_write_data;
      end
      case (op)
        bcf_pkg::OP_ACCEPT: begin
          s_r  <= in_source_vertex;
          nb_r <= in_neighbor_vertex;
        end
        bcf_pkg::OP_CLEAR: begin
          hv_r     <= '0;
          ecount_r <= '0;
          ovf_r    <= 1'b0;
        end
        bcf_pkg::OP_APP1: begin
          if (sts.app_bad) ovf_r <= 1'b1;
        end
        bcf_pkg::OP_APP2: begin
          hv_r[s_r] <= 1'b1;
          ecount_r  <= ecount_r + LW'(1);
        end
        bcf_pkg::OP_INIT: begin
          vis_r   <= '0;
          time_r  <= '0;
          comp_r  <= '0;
          ssize_r <= '0;
          resn_r  <= '0;
          root_r  <= '0;
          k_r     <= '0;
        end
        bcf_pkg::OP_RENT: begin
          u_r      <= root_r[VW-1:0];
          par_r    <= '0;
          hasp_r   <= 1'b0;
          cur_r    <= hv_r[root_r[VW-1:0]] ? LW'(head_rd) : NULL_LINK;
          mark_r   <= '0;
          time_r   <= time_inc;
          disc_u_r <= time_inc;
          low_u_r  <= time_inc;
          vis_r[root_r[VW-1:0]] <= 1'b1;
          depth_r  <= CW'(1);
        end
        bcf_pkg::OP_EDGE: begin
          v_r   <= tgt_rd;
          cur_r <= link_rd;
        end
        bcf_pkg::OP_DEC: begin
          if (tree || back) begin
            if (stack_room) ssize_r <= ssize_r + CW'(1);
            else ovf_r <= 1'b1;
          end
          if (tree) begin
            u_r      <= v_r;
            par_r    <= u_r;
            hasp_r   <= 1'b1;
            cur_r    <= hv_r[v_r] ? LW'(head_rd) : NULL_LINK;
            mark_r   <= ssize_r;
            time_r   <= time_inc;
            disc_u_r <= time_inc;
            low_u_r  <= time_inc;
            vis_r[v_r] <= 1'b1;
            depth_r  <= depth_r + CW'(1);
          end
          if (back && (disc_rd < low_u_r)) low_u_r <= disc_rd;
        end
        bcf_pkg::OP_RET: begin
          depth_r <= depth_m1;
        end
        bcf_pkg::OP_RET2: begin
          u_r      <= frame_rd.vert;
          par_r    <= frame_rd.par;
          hasp_r   <= frame_rd.hasp;
          cur_r    <= frame_rd.cur;
          mark_r   <= frame_rd.mark;
          disc_u_r <= frame_rd.disc;
          low_u_r  <= (low_u_r < frame_rd.low) ? low_u_r : frame_rd.low;
          pmark_r  <= mark_r;
        end
        bcf_pkg::OP_POP_RD: begin
          ssize_r <= ssize_m1;
        end
        bcf_pkg::OP_POP_EMIT, bcf_pkg::OP_DRAIN_EMIT: begin
          if (res_room) resn_r <= resn_r + CW'(1);
          else ovf_r <= 1'b1;
          if (emit_last) comp_r <= comp_r + bcf_pkg::COMP_W'(1);
        end
        bcf_pkg::OP_ROOT_NEXT: begin
          root_r <= root_r + CW'(1);
        end
        bcf_pkg::OP_OLD: begin
          out_edge_from         <= res_rd.edge_v.from_v;
          out_edge_to           <= res_rd.edge_v.to_v;
          out_component_index   <= res_rd.comp;
          out_last_in_component <= res_rd.last;
          out_last_of_run       <= (k_r + CW'(1)) == resn_r;
          out_overflow          <= ovf_r;
        end
        bcf_pkg::OP_OACK: begin
          k_r <= k_r + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/bcf_ctrl.sv
// Controller: sequences loads, the depth-first walk and result delivery
`default_nettype none

module bcf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_command,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire bcf_pkg::sts_t sts,
  output bcf_pkg::op_t       op
);

  bcf_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bcf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and micro-operation
  always_comb begin
    state_nxt = state_r;
    op        = bcf_pkg::OP_NONE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      bcf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_command)
            bcf_pkg::CMD_APPEND: begin
              op        = bcf_pkg::OP_ACCEPT;
              state_nxt = bcf_pkg::S_APP1;
            end
            bcf_pkg::CMD_RUN: begin
              state_nxt = bcf_pkg::S_INIT;
            end
            bcf_pkg::CMD_CLEAR: begin
              op = bcf_pkg::OP_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      bcf_pkg::S_APP1: begin
        op        = bcf_pkg::OP_APP1;
        state_nxt = sts.app_bad ? bcf_pkg::S_IDLE : bcf_pkg::S_APP2;
      end
      bcf_pkg::S_APP2: begin
        op        = bcf_pkg::OP_APP2;
        state_nxt = bcf_pkg::S_IDLE;
      end
      bcf_pkg::S_INIT: begin
        op        = bcf_pkg::OP_INIT;
        state_nxt = bcf_pkg::S_ROOT;
      end
      bcf_pkg::S_ROOT: begin
        if (sts.root_done) begin
          state_nxt = sts.res_empty ? bcf_pkg::S_IDLE : bcf_pkg::S_ORD;
        end else if (sts.root_vis) begin
          state_nxt = bcf_pkg::S_DRAIN;
        end else begin
          op        = bcf_pkg::OP_ROOT_RD;
          state_nxt = bcf_pkg::S_RENT;
        end
      end
      bcf_pkg::S_RENT: begin
        op        = bcf_pkg::OP_RENT;
        state_nxt = bcf_pkg::S_STEP;
      end
      bcf_pkg::S_STEP: begin
        if (sts.cur_null) begin
          state_nxt = bcf_pkg::S_RET;
        end else begin
          op        = bcf_pkg::OP_STEP_RD;
          state_nxt = bcf_pkg::S_EDGE;
        end
      end
      bcf_pkg::S_EDGE: begin
        op        = bcf_pkg::OP_EDGE;
        state_nxt = bcf_pkg::S_DEC;
      end
      bcf_pkg::S_DEC: begin
        op        = bcf_pkg::OP_DEC;
        state_nxt = bcf_pkg::S_STEP;
      end
      bcf_pkg::S_RET: begin
        op        = bcf_pkg::OP_RET;
        state_nxt = sts.depth_one ? bcf_pkg::S_DRAIN : bcf_pkg::S_RET2;
      end
      bcf_pkg::S_RET2: begin
        op        = bcf_pkg::OP_RET2;
        state_nxt = sts.ret_pop ? bcf_pkg::S_POP : bcf_pkg::S_STEP;
      end
      bcf_pkg::S_POP: begin
        op        = bcf_pkg::OP_POP_RD;
        state_nxt = bcf_pkg::S_POPW;
      end
      bcf_pkg::S_POPW: begin
        op        = bcf_pkg::OP_POP_EMIT;
        state_nxt = sts.pop_last ? bcf_pkg::S_STEP : bcf_pkg::S_POP;
      end
      bcf_pkg::S_DRAIN: begin
        if (sts.stack_empty) begin
          op        = bcf_pkg::OP_ROOT_NEXT;
          state_nxt = bcf_pkg::S_ROOT;
        end else begin
          op        = bcf_pkg::OP_POP_RD;
          state_nxt = bcf_pkg::S_DRAINW;
        end
      end
      bcf_pkg::S_DRAINW: begin
        op        = bcf_pkg::OP_DRAIN_EMIT;
        state_nxt = bcf_pkg::S_DRAIN;
      end
      bcf_pkg::S_ORD: begin
        op        = bcf_pkg::OP_ORD;
        state_nxt = bcf_pkg::S_OLD;
      end
      bcf_pkg::S_OLD: begin
        op        = bcf_pkg::OP_OLD;
        state_nxt = bcf_pkg::S_OWAIT;
      end
      bcf_pkg::S_OWAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          op        = bcf_pkg::OP_OACK;
          state_nxt = sts.out_last ? bcf_pkg::S_IDLE : bcf_pkg::S_ORD;
        end
      end
      default: begin
        state_nxt = bcf_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/biconnected_component_finder_top.sv
// Top level of the biconnected component finder
//
//   channel | ports                                    | transfer
//   --------+------------------------------------------+---------------------------
//   in      | in_command, in_source_vertex, in_neighbor_vertex | in_valid & in_ready
//   out     | out_edge_from .. out_overflow            | out_valid & out_ready
//   cfg     | cfg_write_data (vertex count)            | cfg_write_en, no wait
//
// Append accepts the entry, then checks and stores it (a bad entry is dropped); clear
// is done as it is accepted. During a run every step goes through a registered read
// of a store. Results are buffered until the run ends, then leave one at a time.
// Synchronous reset; no clearing pass. Input is not taken during a run or while
// results are delivered; out_ready low holds the current transaction.
`default_nettype none

`include "assert_macros.svh"

module biconnected_component_finder_top #(
  parameter int MAX_ENTRIES = bcf_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_command,
  input  wire logic [bcf_pkg::VERT_W-1:0]   in_source_vertex,
  input  wire logic [bcf_pkg::VERT_W-1:0]   in_neighbor_vertex,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [bcf_pkg::VERT_W-1:0]   out_edge_from,
  output logic      [bcf_pkg::VERT_W-1:0]   out_edge_to,
  output logic      [bcf_pkg::COMP_W-1:0]   out_component_index,
  output logic                              out_last_in_component,
  output logic                              out_last_of_run,
  output logic                              out_overflow,
  input  wire logic                         cfg_write_en,
  input  wire logic [bcf_pkg::VC_W-1:0]     cfg_write_data
);

  bcf_pkg::op_t  op;
  bcf_pkg::sts_t sts;
  logic          run_xfer, last_xfer;

  // Sequencer
  bcf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_command(in_command),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .sts(sts), .op(op));

  // Stores and arithmetic
  bcf_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .sts(sts),
    .in_source_vertex(in_source_vertex), .in_neighbor_vertex(in_neighbor_vertex),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .out_edge_from(out_edge_from), .out_edge_to(out_edge_to),
    .out_component_index(out_component_index),
    .out_last_in_component(out_last_in_component),
    .out_last_of_run(out_last_of_run), .out_overflow(out_overflow));

  // Handshake terms used by the checks
  assign run_xfer  = in_valid && in_ready && (in_command == bcf_pkg::CMD_RUN);
  assign last_xfer = out_valid && out_ready && out_last_of_run;

  // Input is never taken while results are offered
  `BCF_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid, "input taken during output")
  // A run command closes the input side on the next cycle
  `BCF_ASSERT_NXT(a_run_busy, clk, rst_n, run_xfer, !in_ready, "run did not start")
  // The last result of a run reopens the input side
  `BCF_ASSERT_NXT(a_run_end, clk, rst_n, last_xfer, in_ready && !out_valid, "run did not finish")

endmodule

`default_nettype wire
